// ===== hw/rtl/pp_pkg.sv =====
// Package for the polygon perimeter block: widths, limits and the
// sequencer state type. No dependencies.
`default_nettype none

package pp_pkg;

  localparam int CoordW    = 16;              // Q12.4 coordinate
  localparam int DiffW     = CoordW + 1;      // |a - b|, unsigned
  localparam int SqW       = 2 * DiffW - 2;   // one square, 65535^2 < 2^32
  localparam int SumW      = SqW + 1;         // dx^2 + dy^2
  localparam int FracShift = 8;               // Q17.8 result needs 8 more bits
  localparam int RadW      = 42;              // radicand, even, holds SumW + 8
  localparam int RootW     = RadW / 2;        // integer root
  localparam int RemW      = RootW + 1;       // partial remainder
  localparam int SqrtSteps = RootW;           // one result bit per step
  localparam int StepW     = $clog2(SqrtSteps);
  localparam int NumW      = 16;
  localparam int LenW      = 25;
  localparam int PerimW    = 40;

  localparam logic [NumW-1:0]   MaxVertices = 16'd65535;
  localparam logic [NumW-1:0]   MinVertices = 16'd3;
  localparam logic [PerimW-1:0] PerimMax    = {PerimW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SUM,
    ST_ROOT,
    ST_ACCUM,
    ST_EMIT,
    ST_FAULT
  } pp_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/pp_vertex_if.sv =====
// Vertex channel: valid/ready handshake with one vertex per transaction.
// Depends on pp_pkg.
`default_nettype none

interface pp_vertex_if;
  import pp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CoordW-1:0] vertex_x;
  logic [CoordW-1:0] vertex_y;
  logic              final_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output final_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input final_vertex,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pp_result_if.sv =====
// Result channel: valid/ready handshake with one side result per transaction.
// Depends on pp_pkg.
`default_nettype none

interface pp_result_if;
  import pp_pkg::*;

  logic              valid;
  logic              ready;
  logic [NumW-1:0]   side_number;
  logic [LenW-1:0]   side_length;
  logic [PerimW-1:0] perimeter;
  logic              too_few;
  logic              last;

  modport source (output valid, output side_number, output side_length, output perimeter,
                  output too_few, output last, input ready);
  modport sink   (input valid, input side_number, input side_length, input perimeter,
                  input too_few, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pp_sqrt.sv =====
// Bit-serial square root with round to nearest: one root bit per cycle,
// then a rounding step. Depends on pp_pkg.
`default_nettype none

module pp_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pp_pkg::RadW-1:0]   radicand_i,
  output logic                      done_o,
  output logic [pp_pkg::RootW-1:0]  length_o
);
  import pp_pkg::*;

  logic             busy_q, round_q, done_q;
  logic [StepW-1:0] step_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [RootW-1:0] length_q;

  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             fits;
  logic [RemW-1:0]  rem_next;
  logic             round_up;

  always_comb begin
    rem_sh   = {rem_q, rad_q[RadW-1 -: 2]};
    trial    = {1'b0, root_q, 2'b01};
    fits     = (rem_sh >= trial);
    rem_next = fits ? RemW'(rem_sh - trial) : RemW'(rem_sh);
    // round up when the leftover exceeds the root, i.e. past root + 1/2
    round_up = (rem_q > {1'b0, root_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      round_q <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q  <= round_q;
      round_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(SqrtSteps - 1)) begin
          busy_q  <= 1'b0;
          round_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_next;
      root_q <= {root_q[RootW-2:0], fits};
    end
    if (round_q) begin
      length_q <= root_q + RootW'(round_up);
    end
  end

  assign done_o   = done_q;
  assign length_o = length_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (!busy_q && !round_q))
    else $error("square root restarted while busy");
  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({busy_q, round_q, done_q}))
    else $error("square root phases overlap");
  a_round_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && step_q == StepW'(SqrtSteps - 1)) |=> round_q)
    else $error("rounding cycle missed after last step");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/polygon_perimeter.sv =====
// Polygon perimeter: side lengths and running perimeter of a vertex stream.
// Depends on pp_pkg, pp_vertex_if, pp_result_if and pp_sqrt.
//
//   channel    dir  transaction
//   vertex_i   in   vertex_x, vertex_y (Q12.4), final_vertex
//   result_o   out  side_number, side_length (Q17.8), perimeter (Q32.8), too_few, last
//
// A side runs through these steps: difference, two squares on one shared
// 17x17 multiplier, sum, 21 bit-serial root steps, rounding, accumulate.
// A last vertex takes two sides; the first vertex takes none.
// vertex_i.ready is high only while the sequencer is idle.
// A held result waits in the output register; the next vertex is taken
// meanwhile and stalls at its own output step until the register frees.
// Reset clears the polygon state; no clearing pass.
`default_nettype none

module polygon_perimeter (
  input  logic       clk_i,
  input  logic       rst_ni,
  pp_vertex_if.sink  vertex_i,
  pp_result_if.source result_o
);
  import pp_pkg::*;

  pp_state_e state_q, state_d;

  logic [CoordW-1:0] x_q, y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic              fin_q, phase_q;
  logic [NumW-1:0]   total_q, count_q;
  logic [PerimW-1:0] perim_q;
  logic [DiffW-1:0]  dx_q, dy_q;
  logic [SqW-1:0]    prod_q, sqx_q;
  logic [RootW-1:0]  len_q;

  logic              out_valid_q, too_few_q, last_q;
  logic [NumW-1:0]   side_number_q;
  logic [LenW-1:0]   side_length_q;
  logic [PerimW-1:0] perimeter_q;

  logic              accept, slot_free, load_side, load_fault;
  logic [NumW-1:0]   total_in;
  logic              fin_in;
  logic [CoordW-1:0] ax, ay, bx, by;
  logic [DiffW-1:0]  mul_op;
  logic [SumW-1:0]   sq_sum;
  logic              sqrt_start, sqrt_done;
  logic [RadW-1:0]   radicand;
  logic [RootW-1:0]  sqrt_len;
  logic [PerimW:0]   perim_add;

  function automatic logic [DiffW-1:0] abs_diff(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic signed [DiffW:0] d;
    d = $signed({{2{a[CoordW-1]}}, a}) - $signed({{2{b[CoordW-1]}}, b});
    return d[DiffW] ? DiffW'(-d) : d[DiffW-1:0];
  endfunction

  assign accept    = vertex_i.valid && vertex_i.ready;
  assign slot_free = !out_valid_q || result_o.ready;
  assign total_in  = count_q + NumW'(1);
  assign fin_in    = vertex_i.final_vertex || (total_in >= MaxVertices);

  // phase 0: previous vertex to this one; phase 1: closing side to the first
  always_comb begin
    ax = phase_q ? first_x_q : x_q;
    ay = phase_q ? first_y_q : y_q;
    bx = phase_q ? x_q : prev_x_q;
    by = phase_q ? y_q : prev_y_q;
  end

  assign mul_op    = (state_q == ST_SQ_Y) ? dy_q : dx_q;
  assign sq_sum    = SumW'(sqx_q) + SumW'(prod_q);
  assign radicand  = RadW'({sq_sum, {FracShift{1'b0}}});
  assign perim_add = {1'b0, perim_q} + (PerimW + 1)'(len_q);

  pp_sqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .done_o     (sqrt_done),
    .length_o   (sqrt_len)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sqrt_start = 1'b0;
    load_side  = 1'b0;
    load_fault = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (fin_in && (total_in < MinVertices)) begin
            state_d = ST_FAULT;
          end else if (count_q != '0) begin
            state_d = ST_DIFF;
          end
        end
      end
      ST_DIFF:  state_d = ST_SQ_X;
      ST_SQ_X:  state_d = ST_SQ_Y;
      ST_SQ_Y:  state_d = ST_SUM;
      ST_SUM: begin
        sqrt_start = 1'b1;
        state_d    = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          load_side = 1'b1;
          state_d   = (!phase_q && fin_q) ? ST_DIFF : ST_IDLE;
        end
      end
      ST_FAULT: begin
        if (slot_free) begin
          load_fault = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // polygon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      count_q   <= '0;
      perim_q   <= '0;
      phase_q   <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= 1'b0;
        if (count_q == '0) begin
          first_x_q <= vertex_i.vertex_x;
          first_y_q <= vertex_i.vertex_y;
          if (!fin_in) begin
            prev_x_q <= vertex_i.vertex_x;
            prev_y_q <= vertex_i.vertex_y;
            count_q  <= total_in;
          end
        end
      end
      if (state_q == ST_ACCUM) begin
        perim_q <= perim_add[PerimW] ? PerimMax : perim_add[PerimW-1:0];
      end
      if (load_side) begin
        if (!phase_q && fin_q) begin
          phase_q <= 1'b1;
        end else if (!phase_q) begin
          prev_x_q <= x_q;
          prev_y_q <= y_q;
          count_q  <= total_q;
        end else begin
          count_q <= '0;
          perim_q <= '0;
        end
      end
      if (load_fault) begin
        count_q <= '0;
        perim_q <= '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= vertex_i.vertex_x;
      y_q     <= vertex_i.vertex_y;
      fin_q   <= fin_in;
      total_q <= total_in;
    end
    if (state_q == ST_DIFF) begin
      dx_q <= abs_diff(ax, bx);
      dy_q <= abs_diff(ay, by);
    end
    if (state_q == ST_SQ_X || state_q == ST_SQ_Y) begin
      prod_q <= SqW'(mul_op * mul_op);
    end
    if (state_q == ST_SQ_Y) begin
      sqx_q <= prod_q;
    end
    if (state_q == ST_ROOT && sqrt_done) begin
      len_q <= sqrt_len;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_side || load_fault) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_side) begin
      side_number_q <= phase_q ? total_q : count_q;
      side_length_q <= LenW'(len_q);
      perimeter_q   <= perim_q;
      too_few_q     <= 1'b0;
      last_q        <= phase_q;
    end else if (load_fault) begin
      side_number_q <= '0;
      side_length_q <= '0;
      perimeter_q   <= '0;
      too_few_q     <= 1'b1;
      last_q        <= 1'b1;
    end
  end

  assign vertex_i.ready       = (state_q == ST_IDLE);
  assign result_o.valid       = out_valid_q;
  assign result_o.side_number = side_number_q;
  assign result_o.side_length = side_length_q;
  assign result_o.perimeter   = perimeter_q;
  assign result_o.too_few     = too_few_q;
  assign result_o.last        = last_q;

`ifndef NO_ASSERTIONS
  a_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_ROOT))
    else $error("square root finished outside the root wait");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != MaxVertices)
    else $error("vertex count reached the forced-last limit");
  a_close_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_side && phase_q) |=> (out_valid_q && last_q && !too_few_q && count_q == '0))
    else $error("closing side not flagged last or polygon not cleared");
  a_fault_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fault |=> (perimeter_q == '0 && side_number_q == '0 && perim_q == '0))
    else $error("short polygon result not empty");
`endif

endmodule

`default_nettype wire

// ===== verif/pp_perimeter_monitor.sv =====
// Checker for the polygon perimeter block: watches the vertex and result channels,
// predicts side results from accepted vertices and compares them in order.
// Depends on pp_pkg, pp_vertex_if and pp_result_if.

module pp_perimeter_monitor (
  input  logic  clk_i,
  input  logic  rst_ni,
  pp_vertex_if  vertex_mon,
  pp_result_if  result_mon,
  output int    fail_count_o,
  output int    pending_sides_o
);
  import pp_pkg::*;

  typedef struct packed {
    logic [NumW-1:0]   side_number;
    logic [LenW-1:0]   side_length;
    logic [PerimW-1:0] perimeter;
    logic              too_few;
    logic              last;
  } side_result_t;

  side_result_t      expected_sides[$];
  side_result_t      got, want;
  int                errors;

  // current polygon
  logic [CoordW-1:0] origin_x, origin_y;
  logic [CoordW-1:0] tail_x, tail_y;
  logic [NumW-1:0]   seen_vertices;
  longint unsigned   perim_acc;

  function automatic void clear_polygon();
    origin_x      = '0;
    origin_y      = '0;
    tail_x        = '0;
    tail_y        = '0;
    seen_vertices = '0;
    perim_acc     = 0;
  endfunction

  // Euclidean distance of two Q12.4 points in Q17.8, rounded to nearest
  function automatic logic [LenW-1:0] side_len_q17_8(
    logic [CoordW-1:0] ax, logic [CoordW-1:0] ay,
    logic [CoordW-1:0] bx, logic [CoordW-1:0] by
  );
    longint          sdx, sdy;
    longint unsigned dx, dy, sq, rad, root, probe;
    sdx   = longint'($signed(ax)) - longint'($signed(bx));
    sdy   = longint'($signed(ay)) - longint'($signed(by));
    dx    = (sdx < 0) ? -sdx : sdx;
    dy    = (sdy < 0) ? -sdy : sdy;
    sq    = (dx * dx + dy * dy) << FracShift;
    rad   = sq;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rad) probe = probe >> 2;
    while (probe != 0) begin
      if (rad >= root + probe) begin
        rad  = rad - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (sq - root * root > root) root = root + 1;
    return root[LenW-1:0];
  endfunction

  function automatic void add_side(logic [LenW-1:0] len);
    perim_acc = perim_acc + len;
    if (perim_acc > PerimMax) perim_acc = PerimMax;
  endfunction

  function automatic void predict_vertex(
    logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic final_flag
  );
    int                total;
    logic              closing;
    logic [LenW-1:0]   len;
    total   = int'(seen_vertices) + 1;
    closing = final_flag || (total >= int'(MaxVertices));
    if (seen_vertices == 0) begin
      origin_x = x;
      origin_y = y;
    end
    if (closing && total < int'(MinVertices)) begin
      expected_sides.push_back('{'0, '0, '0, 1'b1, 1'b1});
      clear_polygon();
      return;
    end
    if (seen_vertices != 0) begin
      len = side_len_q17_8(x, y, tail_x, tail_y);
      add_side(len);
      expected_sides.push_back('{seen_vertices, len, perim_acc[PerimW-1:0], 1'b0, 1'b0});
    end
    if (closing) begin
      len = side_len_q17_8(origin_x, origin_y, x, y);
      add_side(len);
      expected_sides.push_back('{NumW'(total), len, perim_acc[PerimW-1:0], 1'b0, 1'b1});
      clear_polygon();
      return;
    end
    tail_x        = x;
    tail_y        = y;
    seen_vertices = NumW'(total);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_polygon();
      expected_sides.delete();
      errors = 0;
    end else begin
      // a result never belongs to a vertex taken at the same edge
      if (result_mon.valid && result_mon.ready) begin
        got = '{result_mon.side_number, result_mon.side_length, result_mon.perimeter,
                result_mon.too_few, result_mon.last};
        if (expected_sides.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: num=%0d len=%0d perim=%0d few=%0b last=%0b",
                     got.side_number, got.side_length, got.perimeter, got.too_few,
                     got.last);
          errors++;
        end else begin
          want = expected_sides.pop_front();
          if (got.side_number !== want.side_number || got.side_length !== want.side_length ||
              got.perimeter !== want.perimeter || got.too_few !== want.too_few ||
              got.last !== want.last) begin
            if (errors < 10) begin
              $display("side mismatch: expected num=%0d len=%0d perim=%0d few=%0b last=%0b",
                       want.side_number, want.side_length, want.perimeter, want.too_few,
                       want.last);
              $display("               actual   num=%0d len=%0d perim=%0d few=%0b last=%0b",
                       got.side_number, got.side_length, got.perimeter, got.too_few,
                       got.last);
            end
            errors++;
          end
        end
      end
      if (vertex_mon.valid && vertex_mon.ready)
        predict_vertex(vertex_mon.vertex_x, vertex_mon.vertex_y, vertex_mon.final_vertex);
    end
    fail_count_o    <= errors;
    pending_sides_o <= expected_sides.size();
  end

endmodule

// ===== verif/tb_polygon_perimeter.sv =====
// Testbench top for polygon_perimeter: drives vertex transactions, throttles the
// result channel and reports the verdict. Depends on pp_pkg, the channel
// interfaces, polygon_perimeter and pp_perimeter_monitor.

module tb_polygon_perimeter;
  import pp_pkg::*;

  // slowest run: ~1350 vertices at two sides with full gaps and result stalls,
  // plus the long hold-off
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 100;
  localparam int RandomItems = 1330;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  logic hold_rx = 1'b0;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_sides;

  pp_vertex_if vertex_ch ();
  pp_result_if result_ch ();

  polygon_perimeter uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vertex_i (vertex_ch),
    .result_o (result_ch)
  );

  pp_perimeter_monitor u_perim_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vertex_mon      (vertex_ch),
    .result_mon      (result_ch),
    .fail_count_o    (fail_count),
    .pending_sides_o (pending_sides)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one vertex and hold it until the transaction completes
  task automatic send_vertex(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                             input logic fin);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      vertex_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vertex_ch.valid        <= 1'b1;
    vertex_ch.vertex_x     <= x;
    vertex_ch.vertex_y     <= y;
    vertex_ch.final_vertex <= fin;
    do @(posedge clk_i); while (!(vertex_ch.valid && vertex_ch.ready));
    items_sent++;
  endtask

  function automatic logic [CoordW-1:0] pick_coord(logic [CoordW-1:0] prev);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3, 4: return 16'($urandom);
      default:    return prev + 16'($urandom_range(0, 512)) - 16'd256;
    endcase
  endfunction

  task automatic send_polygon(input int size);
    logic [CoordW-1:0] x, y;
    x = 16'($urandom);
    y = 16'($urandom);
    for (int k = 1; k <= size; k++) begin
      x = pick_coord(x);
      y = pick_coord(y);
      send_vertex(x, y, k == size);
    end
  endtask

  // result side: random stall per transaction, plus the long hold-off
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = rx_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0 || hold_rx) begin
        result_ch.ready <= 1'b0;
        repeat ((stall > 0) ? stall : 1) @(posedge clk_i);
        while (hold_rx) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_ch.valid && result_ch.ready));
    end
  end

  // block the result channel for a long stretch while vertices keep coming
  initial begin
    wait (items_sent >= 400);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (600) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    int size;
    int next_flip;
    vertex_ch.valid        <= 1'b0;
    vertex_ch.vertex_x     <= '0;
    vertex_ch.vertex_y     <= '0;
    vertex_ch.final_vertex <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // too few vertices: one, then two at opposite corners
    send_vertex(16'h1234, 16'hFEDC, 1'b1);
    send_vertex(16'h8000, 16'h8000, 1'b0);
    send_vertex(16'h7FFF, 16'h7FFF, 1'b1);
    // extreme coordinates and longest sides
    send_vertex(16'h8000, 16'h8000, 1'b0);
    send_vertex(16'h7FFF, 16'h8000, 1'b0);
    send_vertex(16'h7FFF, 16'h7FFF, 1'b1);
    send_vertex(16'h8000, 16'h7FFF, 1'b0);
    send_vertex(16'h7FFF, 16'h8000, 1'b0);
    send_vertex(16'h0000, 16'h0000, 1'b1);
    // degenerate: all on one point
    send_vertex(16'h0000, 16'h0000, 1'b0);
    send_vertex(16'h0000, 16'h0000, 1'b0);
    send_vertex(16'h0000, 16'h0000, 1'b1);
    // unit square
    send_vertex(16'h0000, 16'h0000, 1'b0);
    send_vertex(16'h0010, 16'h0000, 1'b0);
    send_vertex(16'h0010, 16'h0010, 1'b0);
    send_vertex(16'h0000, 16'h0010, 1'b1);
    // 3-4-5 triangle, exact lengths
    send_vertex(16'h0000, 16'h0000, 1'b0);
    send_vertex(16'h0030, 16'h0000, 1'b0);
    send_vertex(16'h0030, 16'h0040, 1'b1);
    // finest steps, with rounding
    send_vertex(16'h0001, 16'h0000, 1'b0);
    send_vertex(16'h0000, 16'h0001, 1'b0);
    send_vertex(16'hFFFF, 16'hFFFF, 1'b1);

    next_flip = items_sent + 150;
    while (items_sent < RandomItems) begin
      if (items_sent >= next_flip) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle <= ($urandom_range(0, 3) != 0);
        next_flip = items_sent + 150;
      end
      case ($urandom_range(0, 19))
        0:       size = 1;
        1:       size = 2;
        2:       size = $urandom_range(20, 60);
        default: size = $urandom_range(3, 10);
      endcase
      send_polygon(size);
    end

    vertex_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_sides != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pp_pkg.sv
hw/rtl/pp_vertex_if.sv
hw/rtl/pp_result_if.sv
hw/rtl/pp_sqrt.sv
hw/rtl/polygon_perimeter.sv
verif/pp_perimeter_monitor.sv
verif/tb_polygon_perimeter.sv
